>>> rtl/core/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types, codes and helpers for the bounded deque with delete by value.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int DEPTH   = 16;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int ENTRY_W = 5;
	localparam int OP_W    = 4;

	localparam logic [1:0] CMD_APPEND    = 2'd0;
	localparam logic [1:0] CMD_POP_FRONT = 2'd1;
	localparam logic [1:0] CMD_POP_BACK  = 2'd2;
	localparam logic [1:0] CMD_DELETE    = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
	localparam logic [OP_W-1:0] OP_LOAD       = 4'd1;
	localparam logic [OP_W-1:0] OP_FAIL_FULL  = 4'd2;
	localparam logic [OP_W-1:0] OP_FAIL_EMPTY = 4'd3;
	localparam logic [OP_W-1:0] OP_APPEND     = 4'd4;
	localparam logic [OP_W-1:0] OP_RD_FRONT   = 4'd5;
	localparam logic [OP_W-1:0] OP_RD_BACK    = 4'd6;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 4'd7;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd8;
	localparam logic [OP_W-1:0] OP_SCAN_START = 4'd9;
	localparam logic [OP_W-1:0] OP_SCAN_STEP  = 4'd10;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] removed_value;
		logic [ENTRY_W-1:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} dp_ctl_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       empty;
		logic       full;
		logic       scan_last;
	} dp_stat_t;

	function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
		input logic [IDX_W-1:0] off);
		logic [IDX_W:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (IDX_W + 1)'(DEPTH)) begin
			sum = sum - (IDX_W + 1)'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

>>> rtl/core/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// bdq_ctrl
// Command sequencer: decodes the held command and steps the datapath.
// ----------------------------------------------------------------------------
module bdq_ctrl
	import bdq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output dp_ctl_t  ctl,
	output logic     busy
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_POP  = 2'd2;
	localparam logic [1:0] S_SCAN = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		ctl.op    = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.op    = OP_LOAD;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				state_nxt = S_IDLE;
				priority if (stat.cmd == CMD_APPEND && stat.full) begin
					ctl.op = OP_FAIL_FULL;
				end else if (stat.cmd == CMD_APPEND) begin
					ctl.op = OP_APPEND;
				end else if (stat.empty) begin
					ctl.op = OP_FAIL_EMPTY;
				end else if (stat.cmd == CMD_POP_FRONT) begin
					ctl.op    = OP_RD_FRONT;
					state_nxt = S_POP;
				end else if (stat.cmd == CMD_POP_BACK) begin
					ctl.op    = OP_RD_BACK;
					state_nxt = S_POP;
				end else begin
					ctl.op    = OP_SCAN_START;
					state_nxt = S_SCAN;
				end
			end
			S_POP: begin
				ctl.op    = (stat.cmd == CMD_POP_FRONT) ? OP_POP_FRONT : OP_POP_BACK;
				state_nxt = S_IDLE;
			end
			S_SCAN: begin
				ctl.op = OP_SCAN_STEP;
				if (stat.scan_last) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

>>> rtl/core/bdq_dpath.sv
// ----------------------------------------------------------------------------
// bdq_dpath
// Entry ring, front pointer, count, scan pointer and result registers.
// ----------------------------------------------------------------------------
module bdq_dpath
	import bdq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	input  dp_ctl_t  ctl,
	output dp_stat_t stat,
	output logic     done,
	output rsp_t     rsp
);

	logic [31:0]      mem [DEPTH];
	logic [31:0]      rd_data_q;
	logic [IDX_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       cmd_q;
	logic [31:0]      value_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [CNT_W-1:0] scan_q;
	logic             found_q;
	logic             done_q;
	rsp_t             rsp_q;

	logic             rd_en;
	logic [IDX_W-1:0] rd_off;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_off;
	logic [IDX_W-1:0] wr_addr;
	logic [31:0]      wr_data;
	logic [CNT_W-1:0] cnt_m1;
	logic [CNT_W-1:0] cnt_p1;
	logic             match;
	logic             scan_last;

	assign cnt_m1    = count_q - CNT_W'(1);
	assign cnt_p1    = count_q + CNT_W'(1);
	assign match     = !found_q && (rd_data_q == value_q);
	assign scan_last = (CNT_W'(rd_idx_q) == cnt_m1);

	always_comb begin
		rd_en   = 1'b0;
		rd_off  = '0;
		wr_en   = 1'b0;
		wr_off  = '0;
		wr_data = value_q;
		unique case (ctl.op)
			OP_APPEND: begin
				wr_en  = 1'b1;
				wr_off = count_q[IDX_W-1:0];
			end
			OP_RD_FRONT, OP_SCAN_START: begin
				rd_en = 1'b1;
			end
			OP_RD_BACK: begin
				rd_en  = 1'b1;
				rd_off = cnt_m1[IDX_W-1:0];
			end
			OP_SCAN_STEP: begin
				rd_en   = (scan_q < count_q);
				rd_off  = scan_q[IDX_W-1:0];
				wr_en   = found_q;
				wr_off  = rd_idx_q - IDX_W'(1);
				wr_data = rd_data_q;
			end
			default: begin
			end
		endcase
	end

	assign rd_addr = slot(front_q, rd_off);
	assign wr_addr = slot(front_q, wr_off);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			count_q  <= '0;
			cmd_q    <= CMD_APPEND;
			value_q  <= '0;
			rd_idx_q <= '0;
			scan_q   <= '0;
			found_q  <= 1'b0;
			done_q   <= 1'b0;
			rsp_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (rd_en) begin
				rd_idx_q <= rd_off;
			end
			unique case (ctl.op)
				OP_LOAD: begin
					cmd_q               <= req.cmd;
					value_q             <= req.value;
					found_q             <= 1'b0;
					rsp_q.removed_value <= '0;
				end
				OP_FAIL_FULL: begin
					rsp_q.status      <= ST_FULL;
					rsp_q.entry_count <= ENTRY_W'(count_q);
					done_q            <= 1'b1;
				end
				OP_FAIL_EMPTY: begin
					rsp_q.status      <= ST_EMPTY;
					rsp_q.entry_count <= ENTRY_W'(count_q);
					done_q            <= 1'b1;
				end
				OP_APPEND: begin
					count_q           <= cnt_p1;
					rsp_q.status      <= ST_OK;
					rsp_q.entry_count <= ENTRY_W'(cnt_p1);
					done_q            <= 1'b1;
				end
				OP_POP_FRONT, OP_POP_BACK: begin
					if (ctl.op == OP_POP_FRONT) begin
						front_q <= slot(front_q, IDX_W'(1));
					end
					count_q             <= cnt_m1;
					rsp_q.status        <= ST_OK;
					rsp_q.removed_value <= rd_data_q;
					rsp_q.entry_count   <= ENTRY_W'(cnt_m1);
					done_q              <= 1'b1;
				end
				OP_SCAN_START: begin
					scan_q <= CNT_W'(1);
				end
				OP_SCAN_STEP: begin
					if (rd_en) begin
						scan_q <= scan_q + CNT_W'(1);
					end
					if (match) begin
						found_q             <= 1'b1;
						rsp_q.removed_value <= rd_data_q;
					end
					if (scan_last) begin
						done_q <= 1'b1;
						if (found_q || match) begin
							count_q           <= cnt_m1;
							rsp_q.status      <= ST_OK;
							rsp_q.entry_count <= ENTRY_W'(cnt_m1);
						end else begin
							rsp_q.status      <= ST_NOT_FOUND;
							rsp_q.entry_count <= ENTRY_W'(count_q);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign stat.cmd       = cmd_q;
	assign stat.empty     = (count_q == '0);
	assign stat.full      = (count_q >= CNT_W'(DEPTH));
	assign stat.scan_last = scan_last;
	assign done           = done_q;
	assign rsp            = rsp_q;

endmodule

>>> rtl/core/bounded_deque_delete_by_value.sv
// ----------------------------------------------------------------------------
// bounded_deque_delete_by_value
// Ordered list of up to DEPTH signed 32-bit values kept in a ring memory.
//
// A transaction is taken when start is high and busy is low; req carries the
// command and value. Each transaction yields one result on rsp, shown for
// exactly one cycle while done is high; the receiver cannot stall it.
// Append, and any refused command (full or empty), ends in the execute state.
// Pop front and pop back add a pop state for one registered memory read.
// Delete by value reads every held entry once through the single read port,
// comparing and shifting later entries toward the front in the same pass.
// The result appears in the first cycle that busy is low again; a new
// transaction may start in that same cycle.
// Reset clears the front pointer and the count; no memory clearing is done.
// ----------------------------------------------------------------------------
module bounded_deque_delete_by_value
	import bdq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	dp_ctl_t  ctl;
	dp_stat_t stat;

	bdq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.ctl   (ctl),
		.busy  (busy)
	);

	bdq_dpath u_dpath (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.ctl   (ctl),
		.stat  (stat),
		.done  (done),
		.rsp   (rsp)
	);

`ifndef NO_ASSERTIONS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a transaction in flight");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_FULL) |-> (rsp.entry_count == ENTRY_W'(DEPTH)))
		else $error("full status with a count below capacity");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_EMPTY) |-> (rsp.entry_count == '0))
		else $error("empty status with entries held");
`endif

endmodule

>>> test/deque_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deque_result_checker
// Watches the command and result channels of the bounded deque. It keeps its
// own copy of the ring contents, works out the result that each accepted
// command must produce, and compares every result with the oldest one owed.
// ----------------------------------------------------------------------------
module deque_result_checker
	import bdq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  req_t req,
	input  logic done,
	input  rsp_t rsp,
	output int   outstanding,
	output int   fail_count
);

	logic signed [31:0] ring_vals [DEPTH];
	int                 head_slot;
	int                 occupancy;
	rsp_t               owed_rsp_q [$];
	rsp_t               owed;
	int                 mismatches;

	function automatic int ring_pos(input int offset);
		return (head_slot + offset) % DEPTH;
	endfunction

	function automatic rsp_t apply_to_ring(input req_t r);
		rsp_t o;
		int   hit;
		int   k;
		o.status        = ST_OK;
		o.removed_value = '0;
		if (r.cmd == CMD_APPEND) begin
			if (occupancy >= DEPTH) begin
				o.status = ST_FULL;
			end else begin
				ring_vals[ring_pos(occupancy)] = r.value;
				occupancy++;
			end
		end else if (occupancy == 0) begin
			o.status = ST_EMPTY;
		end else if (r.cmd == CMD_POP_FRONT) begin
			o.removed_value = ring_vals[head_slot];
			head_slot       = ring_pos(1);
			occupancy--;
		end else if (r.cmd == CMD_POP_BACK) begin
			o.removed_value = ring_vals[ring_pos(occupancy - 1)];
			occupancy--;
		end else begin
			hit = -1;
			for (k = 0; k < occupancy; k++) begin
				if (hit < 0 && ring_vals[ring_pos(k)] == r.value) begin
					hit = k;
				end
			end
			if (hit < 0) begin
				o.status = ST_NOT_FOUND;
			end else begin
				o.removed_value = ring_vals[ring_pos(hit)];
				for (k = hit; k + 1 < occupancy; k++) begin
					ring_vals[ring_pos(k)] = ring_vals[ring_pos(k + 1)];
				end
				occupancy--;
			end
		end
		o.entry_count = ENTRY_W'(occupancy);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_slot  = 0;
			occupancy  = 0;
			mismatches = 0;
			owed_rsp_q.delete();
			outstanding <= 0;
			fail_count  <= 0;
		end else begin
			if (done) begin
				if (owed_rsp_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: result with no transaction pending: status %0d removed %0d count %0d",
							$time, rsp.status, rsp.removed_value, rsp.entry_count);
					end
				end else begin
					owed = owed_rsp_q.pop_front();
					if (rsp.status !== owed.status || rsp.removed_value !== owed.removed_value ||
						rsp.entry_count !== owed.entry_count) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: expected status %0d removed %0d count %0d, got status %0d removed %0d count %0d",
								$time, owed.status, owed.removed_value, owed.entry_count,
								rsp.status, rsp.removed_value, rsp.entry_count);
						end
					end
				end
			end
			if (start && !busy) begin
				owed_rsp_q.push_back(apply_to_ring(req));
			end
			outstanding <= owed_rsp_q.size();
			fail_count  <= mismatches;
		end
	end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives commands into the bounded deque: a directed opening over the empty,
// duplicate, not found and extreme value cases, then random phases that fill,
// drain and search the ring with random pauses. A separate checker predicts
// and compares each result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
	import bdq_pkg::*;

	localparam int RAND_ITEMS = 1780;
	localparam int IDLE_LIMIT = 1000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	rsp_t rsp;
	int   outstanding;
	int   fail_count;
	int   quiet_cycles = 0;

	logic signed [31:0] recent_vals [16];
	int                 recent_wr = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	bounded_deque_delete_by_value dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.req   (req),
		.busy  (busy),
		.done  (done),
		.rsp   (rsp)
	);

	deque_result_checker result_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.done       (done),
		.rsp        (rsp),
		.outstanding(outstanding),
		.fail_count (fail_count)
	);

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("bounded_deque_delete_by_value verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic issue(input logic [1:0] c, input logic signed [31:0] v);
		start <= 1'b1;
		req   <= '{cmd: c, value: v};
		if (c == CMD_APPEND) begin
			recent_vals[recent_wr] = v;
			recent_wr = (recent_wr + 1) % 16;
		end
		do @(posedge clk); while (busy);
	endtask

	task automatic pause(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	function automatic logic signed [31:0] pick_value(input bit for_delete);
		int r;
		r = $urandom_range(0, 9);
		if (for_delete && r < 6) begin
			return recent_vals[$urandom_range(0, 15)];
		end
		r = $urandom_range(0, 9);
		if (r < 4) begin
			return $urandom_range(0, 5);
		end else if (r == 4) begin
			case ($urandom_range(0, 3))
				0: return 32'sh7fffffff;
				1: return 32'sh80000000;
				2: return 32'sh0;
				default: return -32'sd1;
			endcase
		end
		return $urandom;
	endfunction

	initial begin
		int         n;
		int         mode;
		int         r;
		bit         idle_on;
		logic [1:0] c;

		foreach (recent_vals[i]) recent_vals[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty ring first, then duplicates and extremes, then removal from the front, the middle and the back.
		issue(CMD_POP_FRONT, 32'sd0);
		issue(CMD_POP_BACK, -32'sd1);
		issue(CMD_DELETE, 32'sd0);
		issue(CMD_APPEND, 32'sh7fffffff);
		issue(CMD_APPEND, 32'sh80000000);
		issue(CMD_APPEND, 32'sd0);
		issue(CMD_APPEND, -32'sd1);
		issue(CMD_APPEND, 32'sd5);
		issue(CMD_APPEND, 32'sd9);
		issue(CMD_APPEND, 32'sd5);
		issue(CMD_DELETE, 32'sd5);
		issue(CMD_DELETE, 32'sd42);
		issue(CMD_DELETE, 32'sh7fffffff);
		issue(CMD_DELETE, 32'sd5);
		issue(CMD_POP_BACK, 32'sd0);
		issue(CMD_POP_FRONT, 32'sd0);
		issue(CMD_POP_FRONT, 32'sd0);
		issue(CMD_POP_BACK, 32'sd0);
		issue(CMD_POP_FRONT, 32'sd0);
		drain();

		mode    = 0;
		idle_on = 1'b0;
		for (n = 0; n < RAND_ITEMS; n++) begin
			if (n % 40 == 0) begin
				mode    = $urandom_range(0, 3);
				idle_on = ($urandom_range(0, 9) < 7);
			end
			if (n > 0 && n % 450 == 0) begin
				drain();
			end
			if (idle_on && n < RAND_ITEMS - 200 && $urandom_range(0, 5) == 0) begin
				pause($urandom_range(1, 18));
			end
			r = $urandom_range(0, 99);
			case (mode)
				0: c = (r < 75) ? CMD_APPEND : CMD_DELETE;
				1: c = (r < 15) ? CMD_APPEND : CMD_POP_FRONT;
				2: c = (r < 40) ? CMD_APPEND : CMD_POP_BACK;
				default: c = (r < 45) ? CMD_APPEND : CMD_DELETE;
			endcase
			if (c != CMD_APPEND && $urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 2))
					0: c = CMD_POP_FRONT;
					1: c = CMD_POP_BACK;
					default: c = CMD_DELETE;
				endcase
			end
			issue(c, pick_value(c == CMD_DELETE));
		end

		drain();
		repeat (24) @(posedge clk);
		if (fail_count == 0) begin
			$display("bounded_deque_delete_by_value verification clean");
		end else begin
			$display("bounded_deque_delete_by_value verification failed");
		end
		$finish;
	end

endmodule
